FILE: rtl/bfl_pkg.sv
// ----------------------------------------------------------------------------
// bfl_pkg
// Shared constants, codes and types for the bounded FIFO with listing.
// ----------------------------------------------------------------------------
package bfl_pkg;

    localparam int DEPTH   = 8;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LIMIT_W = 4;
    localparam int WORD_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_LIST = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [WORD_W-1:0] value;
    } bfl_cmd_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1))
            res = '0;
        else
            res = ptr + 1'b1;
        return res;
    endfunction

endpackage

FILE: rtl/bfl_front.sv
// ----------------------------------------------------------------------------
// bfl_front
// Takes operation words, drops unused codes and holds accepted commands in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bfl_front
    import bfl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               operation,
    input  logic signed [WORD_W-1:0] value,
    output logic                     cmd_valid,
    output bfl_cmd_t                 cmd,
    input  logic                     cmd_pop
);

    bfl_cmd_t   q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign busy      = (cnt_reg == 2'd2);
    assign push      = start && !busy &&
                       (operation == OP_ENQ || operation == OP_DEQ || operation == OP_LIST);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg].kind  <= operation;
            q_mem[wr_ptr_reg].value <= (operation == OP_ENQ) ? value : '0;
        end
    end

endmodule

FILE: rtl/bfl_back.sv
// ----------------------------------------------------------------------------
// bfl_back
// Executes queued commands on the ring store and drives registered results.
// ----------------------------------------------------------------------------
module bfl_back
    import bfl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [LIMIT_W-1:0]        limit,
    input  logic                      cmd_valid,
    input  bfl_cmd_t                  cmd,
    output logic                      cmd_pop,
    output logic                      strobe,
    output logic [1:0]                status,
    output logic signed [WORD_W-1:0]  data,
    output logic                      last
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    logic             state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;

    logic                     strobe_reg, strobe_next;
    logic [1:0]               status_reg, status_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    logic                     last_reg, last_next;

    logic [CNT_W-1:0] eff_limit;
    logic             full;

    assign eff_limit = (limit > LIMIT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(limit);
    assign full      = (count_reg >= eff_limit);
    assign cmd_pop   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        wr_en       = 1'b0;
        rd_addr     = head_reg;
        strobe_next = 1'b0;
        status_next = ST_OK;
        data_next   = '0;
        last_next   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    strobe_next = 1'b1;
                    case (cmd.kind)
                        OP_ENQ:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = ring_next(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                head_next  = ring_next(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                // first word comes out of the read register next cycle
                                strobe_next = 1'b0;
                                pos_next    = head_reg;
                                rem_next    = count_reg;
                                state_next  = S_LIST;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                strobe_next = 1'b1;
                data_next   = rd_data_reg;
                last_next   = (rem_reg == CNT_W'(1));
                pos_next    = ring_next(pos_reg);
                rd_addr     = ring_next(pos_reg);
                rem_next    = rem_reg - 1'b1;
                if (rem_reg == CNT_W'(1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            pos_reg    <= '0;
            rem_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[tail_reg] <= cmd.value;
        rd_data_reg <= mem[rd_addr];
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && status_reg != ST_OK |-> last_reg && data_reg == '0)
        else $error("error status without last or with data");

    a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST && rem_reg == CNT_W'(1)
        |=> state_reg == S_IDLE && strobe_reg && last_reg)
        else $error("list did not end on last word");

    a_list_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |=> $stable(count_reg) && $stable(head_reg))
        else $error("queue changed during list");

endmodule

FILE: rtl/bounded_fifo_with_listing_core.sv
// ----------------------------------------------------------------------------
// bounded_fifo_with_listing_core
// FIFO of signed 32-bit words with a programmable occupancy limit and a
// list command that dumps all stored words oldest first.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (operation, value) is taken on a clock edge with
//   start high and busy low. Code 0 enqueues, 1 dequeues, 2 lists, 3 is
//   dropped without a result.
//   Results: one word per strobe cycle (status, data, last); the receiver
//   must take it, there is no back-pressure on this side.
//   Config: cfg_data (limit) is written on cfg_valid with cfg_ready, which
//   is always high; write only while no command is outstanding.
// Timing:
//   A command reaches the back end through a two-entry queue; busy is high
//   while that queue is full.
//   Enqueue/dequeue: queued, then the result is registered; back end stays idle.
//   List of N words: a setup step for the registered store read, then one
//   word per cycle; an empty list gives one EMPTY result with last set.
// Reset:
//   Queue empty, limit 5, no strobe; stored words are undefined until written.
// ----------------------------------------------------------------------------
module bounded_fifo_with_listing_core
    import bfl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                operation,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      strobe,
    output logic [1:0]                status,
    output logic signed [WORD_W-1:0]  data,
    output logic                      last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [LIMIT_W-1:0]        cfg_data
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               cmd_valid;
    logic               cmd_pop;
    bfl_cmd_t           cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    bfl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    bfl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .strobe    (strobe),
        .status    (status),
        .data      (data),
        .last      (last)
    );

endmodule
